[rtl/tile_map_box_collision_macros.svh]
// ---------------------------------------------------------------------------
// Tile map box collision: assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef TILE_MAP_BOX_COLLISION_MACROS_SVH
`define TILE_MAP_BOX_COLLISION_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define TMBC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tile_map_box_collision: check failed");

// Next-cycle implication
`define TMBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tile_map_box_collision: check failed");

`else

`define TMBC_ASSERT_IMPL(label, ante, cons)
`define TMBC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/tmbc_pkg.sv]
// ---------------------------------------------------------------------------
// tmbc_pkg
// Types, constants and helper functions of the tile map box collision block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmbc_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  localparam int POS_W  = 16;  // Q8.8 position
  localparam int PUSH_W = 9;   // signed push
  localparam int MAG_W  = 8;   // push / overlap magnitude
  localparam int CFG_W  = 7;   // size registers
  localparam int FLD_W  = 6;   // tile_col / tile_row fields
  localparam int DIM_W  = 9;   // clamped map size, at most 127
  localparam int CRD_W  = 10;  // signed tile coordinate
  localparam int DIST_W = 18;  // signed distance in 1/256 tile

  // half of (box size + tile size) = 0.7 tile
  localparam int HALF_SUM = 179;

  localparam logic [CFG_W-1:0] MAP_DIM_RESET = 7'd64;

  // configuration register indexes
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // 3x3 window offset of the last column / row
  localparam logic [1:0] WIN_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_MOD,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } tmbc_state_t;

  // Round a Q8.8 value half away from zero to a whole tile.
  function automatic logic signed [CRD_W-1:0] round_tile(input logic signed [POS_W-1:0] p);
    logic [POS_W:0]   mag;
    logic [POS_W:0]   sum;
    logic [CRD_W-1:0] r;
    mag = p[POS_W-1] ? ((POS_W+1)'(0) - (POS_W+1)'(p)) : (POS_W+1)'(p);
    sum = mag + (POS_W+1)'(128);
    r   = CRD_W'(sum[POS_W:8]);
    return p[POS_W-1] ? $signed(CRD_W'(0) - r) : $signed(r);
  endfunction

  // Saturate a 17-bit sum to the 16-bit position range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W-1:0] res;
    res = v[POS_W-1:0];
    if (v[POS_W] && !v[POS_W-1]) begin
      res = {1'b1, {(POS_W-1){1'b0}}};
    end else if (!v[POS_W] && v[POS_W-1]) begin
      res = {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/tile_map_box_collision.sv]
// ---------------------------------------------------------------------------
// tile_map_box_collision
// Solid tile map with box-versus-tile collision resolution of a position.
// ---------------------------------------------------------------------------
// A query keeps busy high from the accepting edge through a setup state,
// nine neighbour reads (one per cycle from the single-port row memory,
// the 3x3 window in row-then-column order), a drain state for the last
// read and a finish state that forms the result. result_valid is high for
// exactly one cycle after that, and busy is already low in that cycle, so
// a new item can be taken there.
// The receiver cannot stall: result_valid marks the result only in its strobe cycle.
// A tile write is a read-modify-write of one map row in ST_WR_MOD with
// busy high; a write outside MAX_COLS x MAX_ROWS is dropped at once. After
// reset the map is cleared one row per cycle with busy high; the size
// registers can be written at any time the block is idle, including then.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tile_map_box_collision_macros.svh"

module tile_map_box_collision #(
  parameter int MAX_COLS = tmbc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tmbc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 action,
  input  wire logic [tmbc_pkg::FLD_W-1:0]           tile_col,
  input  wire logic [tmbc_pkg::FLD_W-1:0]           tile_row,
  input  wire logic                                 tile_solid,
  input  wire logic signed [tmbc_pkg::POS_W-1:0]    pos_x,
  input  wire logic signed [tmbc_pkg::POS_W-1:0]    pos_z,
  // configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic                                 cfg_index,
  input  wire logic [tmbc_pkg::CFG_W-1:0]           cfg_data,
  // results
  output logic                                      result_valid,
  output logic signed [tmbc_pkg::POS_W-1:0]         new_pos_x,
  output logic signed [tmbc_pkg::POS_W-1:0]         new_pos_z,
  output logic signed [tmbc_pkg::PUSH_W-1:0]        push_x,
  output logic signed [tmbc_pkg::PUSH_W-1:0]        push_z,
  output logic                                      both_axes_hit
);

  import tmbc_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  // configuration registers
  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;

  // control
  tmbc_state_t state;
  tmbc_state_t state_next;
  logic [ROW_W-1:0] clr_row;
  logic [1:0]       scan_i;
  logic [1:0]       scan_j;

  // captured item
  logic signed [POS_W-1:0] q_px;
  logic signed [POS_W-1:0] q_pz;
  logic [COL_W-1:0]        w_col;
  logic [ROW_W-1:0]        w_row;
  logic                    w_solid;

  // window
  logic signed [CRD_W-1:0] rx;
  logic signed [CRD_W-1:0] rz;
  logic [DIM_W-1:0]        wdt;
  logic [DIM_W-1:0]        hgt;
  logic signed [CRD_W-1:0] cell_x;
  logic signed [CRD_W-1:0] cell_z;
  logic                    cell_ok;

  // map memory
  logic [MAX_COLS-1:0] map_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data;
  logic [MAX_COLS-1:0] mem_wdata;
  logic [ROW_W-1:0]    mem_addr;
  logic                mem_we;
  logic                wr_in_range;

  // evaluation stage
  logic                     e_valid;
  logic [COL_W-1:0]         e_col;
  logic [ROW_W-1:0]         e_row;
  logic signed [DIST_W-1:0] dx;
  logic signed [DIST_W-1:0] dz;
  logic [DIST_W-1:0]        adx;
  logic [DIST_W-1:0]        adz;
  logic [DIST_W-1:0]        ox_full;
  logic [DIST_W-1:0]        oz_full;
  logic [MAG_W-1:0]         ox;
  logic [MAG_W-1:0]         oz;
  logic                     overlap;

  // best pushes
  logic [MAG_W-1:0]          bx_mag;
  logic [MAG_W-1:0]          bz_mag;
  logic                      bx_neg;
  logic                      bz_neg;
  logic signed [PUSH_W-1:0]  bx;
  logic signed [PUSH_W-1:0]  bz;
  logic signed [POS_W:0]     sum_x;
  logic signed [POS_W:0]     sum_z;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_DIM_RESET;
      map_height <= MAP_DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
      endcase
    end
  end

  assign wdt = (DIM_W'(map_width) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : DIM_W'(map_width);
  assign hgt = (DIM_W'(map_height) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(map_height);

  assign wr_in_range = (DIM_W'(tile_col) < DIM_W'(MAX_COLS)) &&
                       (DIM_W'(tile_row) < DIM_W'(MAX_ROWS));

  // ---------------------------------------------------------------------
  // Window cell of the current scan step
  // ---------------------------------------------------------------------
  assign cell_x = rx + CRD_W'(scan_i) - CRD_W'(1);
  assign cell_z = rz + CRD_W'(scan_j) - CRD_W'(1);

  // inside the clipped window and not the centre tile
  assign cell_ok = !cell_x[CRD_W-1] && (cell_x < $signed({1'b0, wdt})) &&
                   !cell_z[CRD_W-1] && (cell_z < $signed({1'b0, hgt})) &&
                   !(scan_i == 2'd1 && scan_j == 2'd1);

  // ---------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = ROW_W'(cell_z);
    unique case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_row;
        if (clr_row == ROW_W'(MAX_ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_addr = ROW_W'(tile_row);
        if (start) begin
          if (action == ACT_QUERY) begin
            state_next = ST_SETUP;
          end else if (wr_in_range) begin
            state_next = ST_WR_MOD;
          end
        end
      end
      ST_WR_MOD: begin
        mem_we     = 1'b1;
        mem_addr   = w_row;
        state_next = ST_IDLE;
      end
      ST_SETUP: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_i == WIN_LAST && scan_j == WIN_LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // clear row counter and window scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
      scan_i  <= '0;
      scan_j  <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + ROW_W'(1);
      end
      if (state == ST_SETUP) begin
        scan_i <= '0;
        scan_j <= '0;
      end else if (state == ST_SCAN) begin
        if (scan_i == WIN_LAST) begin
          scan_i <= '0;
          scan_j <= scan_j + 2'd1;
        end else begin
          scan_i <= scan_i + 2'd1;
        end
      end
    end
  end

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      q_px    <= pos_x;
      q_pz    <= pos_z;
      w_col   <= COL_W'(tile_col);
      w_row   <= ROW_W'(tile_row);
      w_solid <= tile_solid;
    end
    if (state == ST_SETUP) begin
      rx <= round_tile(q_px);
      rz <= round_tile(q_pz);
    end
  end

  // ---------------------------------------------------------------------
  // Map memory: one row per entry, read-first single port
  // ---------------------------------------------------------------------
  always_comb begin
    mem_wdata        = rd_data;
    mem_wdata[w_col] = w_solid;
    if (state == ST_CLEAR) begin
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_addr] <= mem_wdata;
    end
    rd_data <= map_mem[mem_addr];
  end

  // ---------------------------------------------------------------------
  // Evaluation: one neighbour per cycle, in the cycle after its read
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= (state == ST_SCAN) && cell_ok;
    end
  end

  always_ff @(posedge clk) begin
    e_col <= COL_W'(cell_x);
    e_row <= ROW_W'(cell_z);
  end

  assign dx  = DIST_W'(q_px) - DIST_W'({e_col, 8'h00});
  assign dz  = DIST_W'(q_pz) - DIST_W'({e_row, 8'h00});
  assign adx = dx[DIST_W-1] ? (DIST_W'(0) - dx) : dx;
  assign adz = dz[DIST_W-1] ? (DIST_W'(0) - dz) : dz;

  assign overlap = (adx < DIST_W'(HALF_SUM)) && (adz < DIST_W'(HALF_SUM));
  assign ox_full = DIST_W'(HALF_SUM) - adx;
  assign oz_full = DIST_W'(HALF_SUM) - adz;
  assign ox      = ox_full[MAG_W-1:0];
  assign oz      = oz_full[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || state == ST_SETUP) begin
      bx_mag <= '0;
      bz_mag <= '0;
      bx_neg <= 1'b0;
      bz_neg <= 1'b0;
    end else if (e_valid && rd_data[e_col] && overlap) begin
      // smaller overlap picks the axis; equal goes to z
      if (ox < oz) begin
        if (ox > bx_mag) begin
          bx_mag <= ox;
          bx_neg <= dx[DIST_W-1] || (dx == '0);
        end
      end else if (oz > bz_mag) begin
        bz_mag <= oz;
        bz_neg <= dz[DIST_W-1] || (dz == '0);
      end
    end
  end

  assign bx = bx_neg ? (PUSH_W'(0) - PUSH_W'(bx_mag)) : PUSH_W'(bx_mag);
  assign bz = bz_neg ? (PUSH_W'(0) - PUSH_W'(bz_mag)) : PUSH_W'(bz_mag);

  assign sum_x = (POS_W+1)'(q_px) + (POS_W+1)'(bx);
  assign sum_z = (POS_W+1)'(q_pz) + (POS_W+1)'(bz);

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      push_x        <= bx;
      push_z        <= bz;
      both_axes_hit <= (bx_mag != '0) && (bz_mag != '0);
      // only the axis of the larger push moves; ties move z
      if (bx_mag > bz_mag) begin
        new_pos_x <= sat_pos(sum_x);
        new_pos_z <= q_pz;
      end else begin
        new_pos_x <= q_px;
        new_pos_z <= sat_pos(sum_z);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `TMBC_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid)
  `TMBC_ASSERT_IMPL(a_eval_after_scan, e_valid, $past(state) == ST_SCAN)
  `TMBC_ASSERT_IMPL(a_push_bound, 1'b1, (bx_mag <= MAG_W'(HALF_SUM)) && (bz_mag <= MAG_W'(HALF_SUM)))
  `TMBC_ASSERT_IMPL(a_one_axis_moves, result_valid, (new_pos_x == q_px) || (new_pos_z == q_pz))
  `TMBC_ASSERT_IMPL(a_both_flag, result_valid, both_axes_hit == ((push_x != '0) && (push_z != '0)))

endmodule

`default_nettype wire
